@@ design/sid_pkg.sv @@
// Shared widths, constants and sequencer states for the signed integer divider.
package sid_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int S_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int M_TUSER_W  = 2;

  localparam logic [DATA_WIDTH-1:0] MIN_VAL  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MAX_VAL  = ~MIN_VAL;
  localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;
  localparam logic [CNT_W-1:0]      LAST_BIT = CNT_W'(DATA_WIDTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX
  } state_t;

endpackage

@@ design/signed_integer_divider.sv @@
// Signed integer divider top level: truncating quotient via radix-2 restoring loop.
// Sequence: the restoring loop yields one quotient bit per cycle into the iteration
// registers, then a sign fix-up step loads the result word into the output register.
// s_tready is low while dividing and during the fix-up, so a new word is accepted
// only once the last has reached the output register; a low m_tready delays that.
// Zero divisor and MIN / -1 skip the loop and go straight to the fix-up step.
// Reset (rst, synchronous, active high) idles the sequencer and empties the output reg.
module signed_integer_divider
  import sid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // slave side
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // dividend, divisor
  // master side
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // quotient
  output logic [M_TUSER_W-1:0] m_tuser    // saturated, divide_by_zero
);

  state_t state, state_next;

  // iteration registers
  logic [DATA_WIDTH-1:0] rem;    // partial remainder
  logic [DATA_WIDTH-1:0] numq;   // dividend bits shift out, quotient bits shift in
  logic [DATA_WIDTH-1:0] den;    // divisor magnitude
  logic [CNT_W-1:0]      cnt;
  logic                  neg;    // result needs negating
  logic                  sat;
  logic                  dz;

  // output register
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_quotient;
  logic                  out_sat;
  logic                  out_dz;

  logic                  in_fire;
  logic                  out_load;
  logic                  out_free;

  // input decode
  logic [DATA_WIDTH-1:0] dividend;
  logic [DATA_WIDTH-1:0] divisor;
  logic                  a_neg;
  logic                  b_neg;
  logic [DATA_WIDTH-1:0] a_mag;
  logic [DATA_WIDTH-1:0] b_mag;
  logic                  b_zero;
  logic                  ovf;

  // shared subtract/compare unit
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  take;

  logic [DATA_WIDTH-1:0] fixed_q;

  assign dividend = s_tdata[DATA_WIDTH-1:0];
  assign divisor  = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
  assign a_neg    = dividend[DATA_WIDTH-1];
  assign b_neg    = divisor[DATA_WIDTH-1];
  assign a_mag    = a_neg ? (~dividend + 1'b1) : dividend;
  assign b_mag    = b_neg ? (~divisor + 1'b1) : divisor;
  assign b_zero   = (divisor == '0);
  assign ovf      = (dividend == MIN_VAL) && (divisor == ALL_ONES);

  assign shifted  = {rem, numq[DATA_WIDTH-1]};
  assign diff     = shifted - {1'b0, den};
  assign take     = (shifted >= {1'b0, den});

  assign fixed_q  = neg ? (~numq + 1'b1) : numq;

  assign out_free = !out_valid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (b_zero || ovf) ? ST_FIX : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DIV:  ;
      ST_FIX:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath: load on accept, one quotient bit per DIV cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rem <= '0;
      den <= b_mag;
      cnt <= LAST_BIT;
      sat <= ovf && !b_zero;
      dz  <= b_zero;
      if (b_zero) begin
        numq <= '0;
        neg  <= 1'b0;
      end else if (ovf) begin
        numq <= MAX_VAL;
        neg  <= 1'b0;
      end else begin
        numq <= a_mag;
        neg  <= a_neg ^ b_neg;
      end
    end else if (state == ST_DIV) begin
      rem  <= take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      numq <= {numq[DATA_WIDTH-2:0], take};
      cnt  <= cnt - 1'b1;
    end
  end

  // output register: holds a finished word while the next item is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_quotient <= fixed_q;
      out_sat      <= sat;
      out_dz       <= dz;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'(out_quotient);
  assign m_tuser  = {out_dz, out_sat};

endmodule
